/* sv/ram_pkg.sv */
// package: widths, operation codes, controller states, command and status structs for the rational unit
`default_nettype none
package ram_pkg;
  localparam int OpBits  = 16;
  localparam int MagBits = OpBits;
  localparam int ProdBits = 2 * MagBits;
  localparam int SumBits = ProdBits + 1;
  localparam int CntBits = $clog2(SumBits + 1);
  localparam int NumBits = 33;
  localparam int DenBits = 31;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_MUL = 1'b1
  } req_type_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD_START,
    ST_GCD_STEP,
    ST_GCD_SWAP,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL1,
    CMD_MUL2,
    CMD_COMB,
    CMD_GCD_START,
    CMD_STEP,
    CMD_SWAP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    div_start;
    logic    div_sel_den;
    logic    out_load;
  } ram_cmd_t;

  typedef struct packed {
    logic zero_den;
    logic num_zero;
    logic rem_zero;
    logic step_done;
    logic div_done;
  } ram_stat_t;
endpackage
`default_nettype wire

/* sv/ram_if.sv */
// valid/ready channel interfaces for request and result
`default_nettype none
interface ram_req_if (input wire logic clk);
  logic              valid;
  logic              ready;
  logic              req_type;
  logic signed [15:0] a_num;
  logic signed [15:0] a_den;
  logic signed [15:0] b_num;
  logic signed [15:0] b_den;
  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface ram_res_if (input wire logic clk);
  logic               valid;
  logic               ready;
  logic signed [32:0] res_num;
  logic        [30:0] res_den;
  logic               zero_den_err;
  modport source (output valid, res_num, res_den, zero_den_err, input ready);
  modport sink (input valid, res_num, res_den, zero_den_err, output ready);
endinterface
`default_nettype wire

/* sv/ram_ctrl.sv */
// controller state machine sequencing products, gcd and divisions
`default_nettype none
module ram_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ram_pkg::ram_cmd_t     cmd,
  input  wire ram_pkg::ram_stat_t stat
);
  import ram_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_MUL1;
      ST_MUL1:      state_next = stat.zero_den ? ST_DONE : ST_MUL2;
      ST_MUL2:      state_next = ST_COMB;
      ST_COMB:      state_next = ST_GCD_START;
      ST_GCD_START: state_next = stat.num_zero ? ST_DONE : ST_GCD_STEP;
      ST_GCD_STEP:  if (stat.step_done) state_next = ST_GCD_SWAP;
      ST_GCD_SWAP:  if (stat.rem_zero) state_next = ST_DIV_NUM;
                    else state_next = ST_GCD_STEP;
      ST_DIV_NUM:   if (stat.div_done) state_next = ST_DIV_DEN;
      ST_DIV_DEN:   if (stat.div_done) state_next = ST_DONE;
      ST_DONE:      if (out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.op = CMD_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = CMD_LOAD;
      end
      ST_MUL1:      cmd.op = CMD_MUL1;
      ST_MUL2:      cmd.op = CMD_MUL2;
      ST_COMB:      cmd.op = CMD_COMB;
      ST_GCD_START: begin
        cmd.op = CMD_GCD_START;
        cmd.div_start = 1'b1;
      end
      ST_GCD_STEP:  cmd.op = CMD_STEP;
      ST_GCD_SWAP: begin
        cmd.op = CMD_SWAP;
        cmd.div_start = 1'b1;
        if (stat.rem_zero) cmd.out_load = 1'b0;
      end
      ST_DIV_NUM: begin
        cmd.op = CMD_STEP;
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel_den = 1'b1;
          cmd.out_load = 1'b1;
        end
      end
      ST_DIV_DEN: begin
        cmd.op = CMD_STEP;
        cmd.div_sel_den = 1'b1;
        if (stat.div_done) cmd.out_load = 1'b1;
      end
      ST_DONE:      out_valid = 1'b1;
      default:      ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_accept_leave: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MUL1)) else $error("bad accept");
`endif
endmodule
`default_nettype wire

/* sv/ram_dp.sv */
// datapath: sign split, products, sum, gcd and shared restoring divider
`default_nettype none
module ram_dp (
  input  wire logic                 clk,
  input  wire logic                 req_type,
  input  wire logic signed [15:0]   a_num,
  input  wire logic signed [15:0]   a_den,
  input  wire logic signed [15:0]   b_num,
  input  wire logic signed [15:0]   b_den,
  input  wire ram_pkg::ram_cmd_t    cmd,
  output ram_pkg::ram_stat_t        stat,
  output logic signed [32:0]        res_num,
  output logic        [30:0]        res_den,
  output logic                      zero_den_err
);
  import ram_pkg::*;

  // operand magnitudes and signs
  logic               op_mul;
  logic [MagBits-1:0] an, ad, bn, bd;
  logic               an_s, ad_s, bn_s, bd_s;
  logic               zden;
  // products and raw fraction
  logic [ProdBits-1:0] p, q;
  logic                p_s, q_s;
  logic [SumBits-1:0]  num, den;
  logic                num_s, den_s;
  // gcd divisor
  logic [SumBits-1:0]  gy;
  // divider
  logic [SumBits-1:0]  dv_rem, dv_quo, dv_div;
  logic [CntBits-1:0]  dv_cnt;
  logic                dv_busy;
  logic [SumBits:0]    dv_trial;
  logic [SumBits-1:0]  dv_dvd_next;

  function automatic logic [MagBits-1:0] mag_of(input logic [15:0] v);
    logic [15:0] m;
    m = v[15] ? (16'd0 - v) : v;
    return m;
  endfunction

  assign dv_trial = {1'b0, dv_rem[SumBits-2:0], dv_quo[SumBits-1]} - {1'b0, dv_div};

  // operand capture, products, combine and gcd divisor updates
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        op_mul <= (req_type == REQ_MUL);
        an <= mag_of(a_num); an_s <= a_num[15];
        ad <= mag_of(a_den); ad_s <= a_den[15];
        bn <= mag_of(b_num); bn_s <= b_num[15];
        bd <= mag_of(b_den); bd_s <= b_den[15];
        zden <= (a_den == '0) || (b_den == '0);
      end
      CMD_MUL1: begin
        p <= op_mul ? an * bn : an * bd;
        p_s <= op_mul ? (an_s ^ bn_s) : (an_s ^ bd_s);
        den <= {1'b0, ProdBits'(ad) * ProdBits'(bd)};
        den_s <= ad_s ^ bd_s;
      end
      CMD_MUL2: begin
        q <= bn * ad;
        q_s <= bn_s ^ ad_s;
      end
      CMD_COMB: begin
        if (op_mul) begin
          num <= {1'b0, p}; num_s <= p_s;
        end else if (p_s == q_s) begin
          num <= {1'b0, p} + {1'b0, q}; num_s <= p_s;
        end else if (p >= q) begin
          num <= {1'b0, p - q}; num_s <= p_s;
        end else begin
          num <= {1'b0, q - p}; num_s <= q_s;
        end
      end
      CMD_GCD_START: begin
        gy <= den;
      end
      CMD_SWAP: if (!stat.rem_zero) begin
        gy <= dv_rem;
      end
      default: ;
    endcase
  end

  // restoring divider: quotient shifts in one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_busy <= 1'b1;
      dv_cnt <= CntBits'(SumBits);
      dv_rem <= '0;
      if (cmd.op == CMD_GCD_START) begin
        dv_quo <= num; dv_div <= den;
      end else if (cmd.op == CMD_SWAP && !stat.rem_zero) begin
        dv_quo <= gy; dv_div <= dv_rem;
      end else if (cmd.div_sel_den) begin
        dv_quo <= den; dv_div <= dv_div;
      end else begin
        dv_quo <= num; dv_div <= gy;
      end
    end else if (dv_busy) begin
      if (!dv_trial[SumBits]) dv_rem <= dv_trial[SumBits-1:0];
      else dv_rem <= {dv_rem[SumBits-2:0], dv_quo[SumBits-1]};
      dv_quo <= dv_dvd_next;
      dv_cnt <= dv_cnt - 1'b1;
      if (dv_cnt == CntBits'(1)) dv_busy <= 1'b0;
    end
  end
  assign dv_dvd_next = {dv_quo[SumBits-2:0], ~dv_trial[SumBits]};

  // result register: error and zero results; numerator quotient lands as the denominator division starts
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_MUL1 && zden) begin
      res_num <= '0; res_den <= '0; zero_den_err <= 1'b1;
    end else if (cmd.op == CMD_GCD_START && num == '0) begin
      res_num <= '0; res_den <= DenBits'(1); zero_den_err <= 1'b0;
    end else if (cmd.out_load && cmd.div_start) begin
      res_num <= (num_s != den_s) ? NumBits'(SumBits'(0) - dv_quo) : NumBits'(dv_quo);
      zero_den_err <= 1'b0;
    end else if (cmd.out_load) begin
      res_den <= dv_quo[DenBits-1:0];
    end
  end

  assign stat.zero_den  = zden;
  assign stat.num_zero  = (num == '0);
  assign stat.rem_zero  = (dv_rem == '0);
  assign stat.step_done = !dv_busy;
  assign stat.div_done  = !dv_busy;
endmodule
`default_nettype wire

/* sv/rational_add_multiply_reduce.sv */
// top level: rational add/multiply with gcd reduction
//  channel | dir | fields
//  req     | in  | req_type a_num a_den b_num b_den
//  res     | out | res_num res_den zero_den_err
// one item at a time: products and combine after the transfer, then gcd
// steps (a 33-bit bit-serial division plus a swap) and two divisions for
// the quotients; a zero denominator ends after the first product, a zero
// sum before the gcd
// reset rst is synchronous; the result holds until taken, no input meanwhile
`default_nettype none
module rational_add_multiply_reduce (
  input wire logic clk,
  input wire logic rst,
  ram_req_if.sink  req,
  ram_res_if.source res
);
  import ram_pkg::*;

  ram_cmd_t  cmd;
  ram_stat_t stat;

  ram_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .cmd(cmd), .stat(stat)
  );

  ram_dp u_dp (
    .clk(clk), .req_type(req.req_type),
    .a_num(req.a_num), .a_den(req.a_den), .b_num(req.b_num), .b_den(req.b_den),
    .cmd(cmd), .stat(stat),
    .res_num(res.res_num), .res_den(res.res_den), .zero_den_err(res.zero_den_err)
  );
endmodule
`default_nettype wire

/* tb/ram_checker.sv */
// checker: watches request and result channels, predicts and compares results
`timescale 1ns / 100ps
`default_nettype none
module ram_checker (
  input  wire logic clk,
  input  wire logic rst,
  ram_req_if.sink   req_mon,
  ram_res_if.sink   res_mon,
  output int        fail_count,
  output int        pending
);
  import ram_pkg::*;

  typedef struct {
    logic signed [32:0] num;
    logic [30:0]        den;
    logic               err;
  } frac_res_t;

  frac_res_t expected_q[$];

  function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // reduced result of one rational request
  function automatic frac_res_t reduce_frac(req_type_t op, logic signed [15:0] an,
                                            logic signed [15:0] ad, logic signed [15:0] bn,
                                            logic signed [15:0] bd);
    frac_res_t r;
    longint signed num, den, m;
    longint unsigned un, ud, ug;
    if (ad == 0 || bd == 0) begin
      r.num = '0; r.den = '0; r.err = 1'b1;
      return r;
    end
    den = longint'(ad) * longint'(bd);
    if (op == REQ_MUL) num = longint'(an) * longint'(bn);
    else num = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
    r.err = 1'b0;
    if (num == 0) begin
      r.num = '0; r.den = 31'd1;
      return r;
    end
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    ug = gcd_mag(un, ud);
    un = un / ug;
    ud = ud / ug;
    m = ((num < 0) != (den < 0)) ? -longint'(un) : longint'(un);
    r.num = m[32:0];
    r.den = ud[30:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // predict on each request transfer, compare on each result transfer
  always @(posedge clk) begin
    frac_res_t e;
    if (!rst) begin
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(reduce_frac(req_type_t'(req_mon.req_type), req_mon.a_num,
                                         req_mon.a_den, req_mon.b_num, req_mon.b_den));
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (res_mon.res_num !== e.num)
            report_mismatch($sformatf("res_num %0d exp %0d", res_mon.res_num, e.num));
          if (res_mon.res_den !== e.den)
            report_mismatch($sformatf("res_den %0d exp %0d", res_mon.res_den, e.den));
          if (res_mon.zero_den_err !== e.err)
            report_mismatch($sformatf("zero_den_err %0b exp %0b",
                                      res_mon.zero_den_err, e.err));
        end
      end
      pending = expected_q.size();
    end
  end
endmodule
`default_nettype wire

/* tb/rational_add_multiply_reduce_tb.sv */
// testbench top: clock, reset, request stimulus, result stalls and verdict
`timescale 1ns / 100ps
`default_nettype none
module rational_add_multiply_reduce_tb;
  import ram_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  bit   no_idle;

  ram_req_if req (clk);
  ram_res_if res (clk);

  rational_add_multiply_reduce u_dut (.clk(clk), .rst(rst), .req(req), .res(res));
  ram_checker u_chk (.clk(clk), .rst(rst), .req_mon(req), .res_mon(res),
                     .fail_count(fail_count), .pending(pending));

  always #6 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.a_num = '0; req.a_den = 16'sd1; req.b_num = '0; req.b_den = 16'sd1;
    res.ready = 1'b0;
  end

  // result stalls: about a quarter of cycles, none during the quiet stretch
  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 25);
  end

  function automatic logic signed [15:0] pick_operand();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'(signed'($urandom_range(8)) - 4);
      4: return 16'(signed'($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  // one request transfer, with an optional idle gap first; valid stays high after
  task automatic send_req(req_type_t op, logic signed [15:0] an, logic signed [15:0] ad,
                          logic signed [15:0] bn, logic signed [15:0] bd);
    if (!no_idle)
      while ($urandom_range(99) < 25) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    req.valid <= 1'b1;
    req.req_type <= op;
    req.a_num <= an; req.a_den <= ad; req.b_num <= bn; req.b_den <= bd;
    do @(posedge clk); while (!req.ready);
  endtask

  initial begin
    no_idle = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, both operations, zero denominators, zero result
    send_req(REQ_ADD, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
    send_req(REQ_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
    send_req(REQ_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_req(REQ_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_req(REQ_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_req(REQ_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_req(REQ_ADD, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_req(REQ_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
    send_req(REQ_MUL, 16'sd1, 16'sd1, 16'sd1, 16'sd0);
    send_req(REQ_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_req(REQ_ADD, 16'sd3, 16'sd4, -16'sd3, 16'sd4);
    send_req(REQ_MUL, 16'sd0, -16'sd5, 16'sd7, 16'sd3);
    send_req(REQ_ADD, 16'sd1, -16'sd2, 16'sd1, -16'sd3);
    send_req(REQ_MUL, -16'sd6, 16'sd4, 16'sd2, -16'sd9);
    send_req(REQ_ADD, 16'sd1, 16'sd1, -16'sd1, -16'sd1);
    send_req(REQ_ADD, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
    req.valid <= 1'b0;
    // hold off until every result is back
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // random part, with a stretch free of idling in the middle
    for (int n = 0; n < 1200; n++) begin
      no_idle = (n >= 500 && n < 650);
      send_req(req_type_t'($urandom_range(1)), pick_operand(), pick_operand(),
               pick_operand(), pick_operand());
    end
    req.valid <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (900) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #(12ns * 20000000);
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
